// ===== sv/pls_pkg.sv =====
// Shared constants for the positional list store.
package pls_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

// ===== sv/positional_list_store.sv =====
// A command is captured in the input register; its result (out_valid) is captured in the result register.
// Throughput: one command per cycle; busy stays low, every cell shifts or holds in parallel.
// Each result is on the out_ ports for exactly one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the list and drops any command in flight.
// Entry storage is not reset; only entries below the count are ever read.
module positional_list_store
  import pls_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [POS_W-1:0]         in_position,
  input  logic                     in_at_end,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [STAT_W-1:0]        out_status,
  output logic [COUNT_W-1:0]       out_entry_count
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  // input register
  logic                  s1_valid_r;
  logic [CMD_W-1:0]      s1_cmd_r;
  logic [POS_W-1:0]      s1_pos_r;
  logic                  s1_at_end_r;
  logic [DATA_W-1:0]     s1_value_r;

  // list state
  logic [WORD_WIDTH-1:0] entries_r [DEPTH];
  logic [WORD_WIDTH-1:0] entries_nxt [DEPTH];
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;

  // result register
  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_read_value_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [COUNT_W-1:0]    out_entry_count_r;

  logic [CMPW-1:0]       cnt_ext;
  logic [CMPW-1:0]       pos_ext;
  logic                  full;
  logic                  empty;
  logic                  do_ins;
  logic                  do_del;
  logic                  do_get;
  logic [IW-1:0]         idx;
  logic [STAT_W-1:0]     status;
  logic [WORD_WIDTH-1:0] val_word;
  logic signed [63:0]    rd_wide;
  logic [DATA_W-1:0]     rd_val;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_cmd_r    <= in_command;
      s1_pos_r    <= in_position;
      s1_at_end_r <= in_at_end;
      s1_value_r  <= in_value;
    end
  end

  always_comb begin
    cnt_ext  = CMPW'(count_r);
    pos_ext  = CMPW'(s1_pos_r);
    full     = (count_r == CW'(DEPTH));
    empty    = (count_r == '0);
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_get   = 1'b0;
    idx      = '0;
    status   = ST_OK;
    val_word = WORD_WIDTH'({32'b0, s1_value_r});

    case (s1_cmd_r)
      CMD_INSERT, CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else if (s1_cmd_r == CMD_APPEND || pos_ext >= cnt_ext) begin
          do_ins = 1'b1;
          idx    = IW'(count_r);
          if (s1_cmd_r == CMD_INSERT && pos_ext > cnt_ext) begin
            status = ST_RANGE;
          end
        end else begin
          do_ins = 1'b1;
          idx    = IW'(s1_pos_r);
        end
      end
      CMD_DELETE, CMD_GET: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (s1_at_end_r || pos_ext < cnt_ext) begin
          idx    = s1_at_end_r ? IW'(count_r - CW'(1)) : IW'(s1_pos_r);
          do_del = (s1_cmd_r == CMD_DELETE);
          do_get = (s1_cmd_r == CMD_GET);
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // each cell takes its left neighbor, the new word, its right neighbor, or holds
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      entries_nxt[k] = entries_r[k];
      if (s1_valid_r && do_ins) begin
        if (k == int'(idx)) begin
          entries_nxt[k] = val_word;
        end else if (k > int'(idx)) begin
          entries_nxt[k] = entries_r[(k > 0) ? k - 1 : 0];
        end
      end else if (s1_valid_r && do_del) begin
        if (k >= int'(idx) && k < DEPTH - 1) begin
          entries_nxt[k] = entries_r[(k < DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (s1_valid_r && do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (s1_valid_r && do_del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    rd_wide = 64'(signed'(entries_r[idx]));
    rd_val  = do_get ? rd_wide[DATA_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      entries_r[k] <= entries_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_read_value_r  <= rd_val;
      out_status_r      <= status;
      out_entry_count_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

  // count never runs past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  // every accepted command yields a result on out_valid, through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("missing result for accepted transaction");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + CW'(1)
         || count_r == $past(count_r) - CW'(1)))
    else $error("entry count jumped");

  // a full status is reported only at capacity
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (count_r == CW'(DEPTH)))
    else $error("full status below capacity");

  // read data is zero for any result whose status is not OK
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == '0))
    else $error("read value on failed transaction");

endmodule

// ===== dv/positional_list_store_tb.sv =====
// Testbench for positional_list_store: directed and random commands against a scoreboard.
`timescale 1ns / 1ps

module positional_list_store_tb;
  import pls_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } traffic_mix_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
  } list_result_t;

  // Mirror of the list contents plus the queue of results still owed by the block.
  class list_scoreboard;
    logic signed [DATA_W-1:0] entries[DEPTH_DEF];
    int unsigned              count;
    list_result_t             expected_q[$];
    int                       errors;

    function void note_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic at_end, input logic [DATA_W-1:0] val);
      list_result_t res;
      int unsigned  idx;
      bit           hit;
      res.read_value = '0;
      res.status     = ST_OK;
      if (cmd == CMD_INSERT || cmd == CMD_APPEND) begin
        if (count >= DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          if (cmd == CMD_APPEND || pos >= count) begin
            if (cmd == CMD_INSERT && pos > count) res.status = ST_RANGE;
            idx = count;
          end else begin
            idx = pos;
          end
          for (int unsigned k = count; k > idx; k--) entries[k] = entries[k-1];
          entries[idx] = val;
          count++;
        end
      end else if (count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        hit = 1'b1;
        idx = 0;
        if (at_end) begin
          idx = count - 1;
        end else if (pos < count) begin
          idx = pos;
        end else begin
          hit = 1'b0;
          res.status = ST_RANGE;
        end
        if (hit) begin
          if (cmd == CMD_DELETE) begin
            for (int unsigned k = idx; k + 1 < count; k++) entries[k] = entries[k+1];
            count--;
          end else begin
            res.read_value = entries[idx];
          end
        end
      end
      res.entry_count = COUNT_W'(count);
      expected_q.push_back(res);
    endfunction

    function void check_result(input logic signed [DATA_W-1:0] rd,
                               input logic [STAT_W-1:0] st, input logic [COUNT_W-1:0] cnt);
      list_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding: read_value %0d status %0d entry_count %0d",
               rd, st, cnt);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (rd !== exp_res.read_value) begin
        $error("read_value: expected %0d, got %0d", exp_res.read_value, rd);
        errors++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, st);
        errors++;
      end
      if (cnt !== exp_res.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp_res.entry_count, cnt);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_command;
  logic [POS_W-1:0]         in_position;
  logic                     in_at_end;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_read_value;
  logic [STAT_W-1:0]        out_status;
  logic [COUNT_W-1:0]       out_entry_count;

  list_scoreboard sb;
  int             taken;
  int             idle_cycles;

  positional_list_store uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_at_end      (in_at_end),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor and watchdog; results are checked before the same-edge command is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_read_value, out_status, out_entry_count);
      if (start && !busy) begin
        sb.note_command(in_command, in_position, in_at_end, in_value);
        taken++;
      end
      if (out_valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("positional_list_store_tb: errors");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic at_end, input logic [DATA_W-1:0] val);
    int taken_prev;
    taken_prev  = taken;
    start       = 1'b1;
    in_command  = cmd;
    in_position = pos;
    in_at_end   = at_end;
    in_value    = val;
    do @(negedge clk); while (taken == taken_prev);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 80) return WORD_MAX;
    if (r < 90) return WORD_MIN;
    if (r < 95) return '0;
    return WORD_ONES;
  endfunction

  task automatic random_command(input traffic_mix_t mix);
    int               r;
    int unsigned      fill;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic             at_end;
    r    = $urandom_range(0, 99);
    fill = sb.count;
    case (mix)
      MIX_GROW:   cmd = (r < 45) ? CMD_INSERT : (r < 75) ? CMD_APPEND :
                        (r < 88) ? CMD_GET : CMD_DELETE;
      MIX_SHRINK: cmd = (r < 10) ? CMD_INSERT : (r < 20) ? CMD_APPEND :
                        (r < 45) ? CMD_GET : CMD_DELETE;
      default:    cmd = (r < 25) ? CMD_INSERT : (r < 50) ? CMD_APPEND :
                        (r < 75) ? CMD_GET : CMD_DELETE;
    endcase
    // Mostly valid positions, with some noise across the whole field.
    if ($urandom_range(0, 99) < 80) begin
      if (cmd == CMD_INSERT || cmd == CMD_APPEND) pos = POS_W'($urandom_range(0, fill));
      else pos = (fill > 0) ? POS_W'($urandom_range(0, fill - 1)) : '0;
    end else begin
      pos = POS_W'($urandom_range(0, 31));
    end
    if (cmd == CMD_DELETE || cmd == CMD_GET) at_end = ($urandom_range(0, 99) < 30);
    else at_end = 1'($urandom_range(0, 1));
    issue_command(cmd, pos, at_end, pick_word());
  endtask

  initial begin
    int           sent;
    int           phase_len;
    bit           quiet;
    traffic_mix_t mix;
    sb          = new();
    taken       = 0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = CMD_INSERT;
    in_position = '0;
    in_at_end   = 1'b0;
    in_value    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, only-entry delete, past-end cases, extremes, full store.
    issue_command(CMD_GET, 5'd0, 1'b0, '0);
    issue_command(CMD_DELETE, 5'd0, 1'b1, '0);
    issue_command(CMD_INSERT, 5'd0, 1'b0, WORD_MAX);
    issue_command(CMD_DELETE, 5'd0, 1'b0, '0);
    issue_command(CMD_INSERT, 5'd31, 1'b1, WORD_MIN);
    issue_command(CMD_APPEND, 5'd31, 1'b0, WORD_ONES);
    issue_command(CMD_INSERT, 5'd2, 1'b0, '0);
    issue_command(CMD_INSERT, 5'd1, 1'b0, 32'h5A5A_5A5A);
    issue_command(CMD_GET, 5'd0, 1'b0, '0);
    issue_command(CMD_GET, 5'd31, 1'b1, '0);
    issue_command(CMD_GET, 5'd4, 1'b0, '0);
    issue_command(CMD_DELETE, 5'd16, 1'b0, '0);
    issue_command(CMD_DELETE, 5'd1, 1'b0, '0);
    issue_command(CMD_DELETE, 5'd31, 1'b1, WORD_ONES);
    while (sb.count < DEPTH_DEF)
      issue_command(CMD_INSERT, POS_W'($urandom_range(0, sb.count)), 1'b0, $urandom);
    issue_command(CMD_APPEND, 5'd0, 1'b0, WORD_MAX);
    issue_command(CMD_INSERT, 5'd0, 1'b0, WORD_MIN);
    issue_command(CMD_GET, 5'd15, 1'b0, '0);
    issue_command(CMD_DELETE, 5'd0, 1'b0, '0);

    // Random: phases that fill, drain or churn the list, some with back-to-back traffic.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix       = traffic_mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 60);
      quiet     = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (!quiet) hold_off(pick_gap());
        random_command(mix);
        sent++;
      end
    end

    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("positional_list_store_tb: clean");
    end else begin
      $display("positional_list_store_tb: errors");
    end
    $finish;
  end

endmodule
